/* rtl/row_neighbor_bright_edge_filter_top_defines.svh */
// ============================================================================
// Assertion macros for the row neighbor bright edge filter
// Shared property forms for the port-level checker.
// ============================================================================
`ifndef ROW_NEIGHBOR_BRIGHT_EDGE_FILTER_TOP_DEFINES_SVH
`define ROW_NEIGHBOR_BRIGHT_EDGE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RNBE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RNBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rnbe_pkg.sv */
// ============================================================================
// Row neighbor bright edge filter package
// Shared constants, register codes and word types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package rnbe_pkg;

	localparam int SAMPLE_BITS  = 20;
	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int CFG_GEOM_BITS = 13;
	localparam int DTHR_BITS    = 19;
	localparam int BTHR_BITS    = 20;
	localparam int CNT_BITS     = $clog2(MAX_WIDTH);
	localparam int EW_BITS      = CNT_BITS + 1;
	localparam int HCNT_BITS    = $clog2(HEIGHT_LIMIT);
	localparam int EH_BITS      = HCNT_BITS + 1;
	localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CMP_BITS     = (SAMPLE_BITS + 2 > DTHR_BITS + 2) ? SAMPLE_BITS + 2
		: DTHR_BITS + 2;
	localparam int QDEPTH       = 4;
	localparam int QPTR_BITS    = $clog2(QDEPTH);
	localparam int PADDR_BITS   = 4;
	localparam int PDATA_BITS   = 32;

	typedef enum logic [1:0] {
		REG_ROW_WIDTH,
		REG_FRAME_HEIGHT,
		REG_DIFF_THR,
		REG_BRIGHT_THR
	} reg_index_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [EW_BITS-1:0]          width;
		logic [EH_BITS-1:0]          height;
		logic [DTHR_BITS-1:0]        diff_thr;
		logic signed [BTHR_BITS-1:0] bright_thr;
		logic                        geom_clear;
	} cfg_t;

	typedef struct packed {
		sample_t sample;
		logic    row_end;
		logic    frame_end;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} item_t;

endpackage
`default_nettype wire

/* rtl/row_neighbor_bright_edge_filter_top.sv */
// ============================================================================
// Row neighbor bright edge filter, top level
// Replaces a pixel by a bright neighbor across a strong left/right step.
// ============================================================================
// Samples enter on the s_ stream, one word per sample in raster order, with
// the signed Q.8 value in s_tdata. Results leave on the m_ stream: sample in
// m_tdata, row end on m_tlast, frame end on m_tuser[0] and the last result
// of an input sample on m_tuser[1]. In rows wider than one sample the first
// gives no result and the last gives two, so output lags input by one sample.
// A result word is pushed into the queue when the sample that completes it
// is accepted, then loaded into the output register. The block takes one
// sample per cycle; the four-item queue between the front end and the back
// end absorbs the extra word at each row end. Samples are held off while
// that queue is full, which happens only when the receiver stalls, and in
// the cycle of a width or height register write; the front end keeps working
// until then. Reset clears the stream position, the queue and the output
// stage and loads the register defaults; writing the width or height
// registers restarts the frame with the next sample.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module row_neighbor_bright_edge_filter_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rnbe_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [rnbe_pkg::PDATA_BITS-1:0] pwdata,
	output logic      [rnbe_pkg::PDATA_BITS-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: sample_in, then zero fill.
	input  wire logic [rnbe_pkg::TDATA_BITS-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// Fields from bit 0: sample_out, then zero fill.
	output logic      [rnbe_pkg::TDATA_BITS-1:0] m_tdata,
	output logic                                 m_tlast,
	// Fields from bit 0: frame_end, run_last.
	output logic      [1:0]                      m_tuser
);
	import rnbe_pkg::*;

	cfg_t  cfg;
	logic  q_full;
	logic  q_nonempty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t q_head;

	rnbe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rnbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_sample (s_tdata[SAMPLE_BITS-1:0]),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.push      (push),
		.push_item (push_item)
	);

	rnbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	rnbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

/* rtl/rnbe_cfg.sv */
// ============================================================================
// Configuration registers
// APB register file with effective geometry clamping.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module rnbe_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rnbe_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [rnbe_pkg::PDATA_BITS-1:0] pwdata,
	output logic      [rnbe_pkg::PDATA_BITS-1:0] prdata,
	output logic                                pready,
	output rnbe_pkg::cfg_t                      cfg
);
	import rnbe_pkg::*;

	logic [CFG_GEOM_BITS-1:0]    width_q;
	logic [CFG_GEOM_BITS-1:0]    height_q;
	logic [DTHR_BITS-1:0]        dthr_q;
	logic signed [BTHR_BITS-1:0] bthr_q;
	logic                        wr;
	reg_index_t                  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_GEOM_BITS'(512);
			height_q <= CFG_GEOM_BITS'(512);
			dthr_q   <= DTHR_BITS'(1280);
			bthr_q   <= BTHR_BITS'(40960);
		end else begin
			if (wr) begin
				unique case (idx)
					REG_ROW_WIDTH: begin
						width_q <= pwdata[CFG_GEOM_BITS-1:0];
					end
					REG_FRAME_HEIGHT: begin
						height_q <= pwdata[CFG_GEOM_BITS-1:0];
					end
					REG_DIFF_THR:   dthr_q <= pwdata[DTHR_BITS-1:0];
					REG_BRIGHT_THR: bthr_q <= pwdata[BTHR_BITS-1:0];
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW_WIDTH:    prdata = PDATA_BITS'(width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_BITS'(height_q);
			REG_DIFF_THR:     prdata = PDATA_BITS'(dthr_q);
			REG_BRIGHT_THR:   prdata = PDATA_BITS'(bthr_q);
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			cfg.width = EW_BITS'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg.width = EW_BITS'(MAX_WIDTH);
		end else begin
			cfg.width = EW_BITS'(width_q);
		end
		if (height_q == '0) begin
			cfg.height = EH_BITS'(1);
		end else if (32'(height_q) > HEIGHT_LIMIT) begin
			cfg.height = EH_BITS'(HEIGHT_LIMIT);
		end else begin
			cfg.height = EH_BITS'(height_q);
		end
		cfg.diff_thr   = dthr_q;
		cfg.bright_thr = bthr_q;
		cfg.geom_clear = wr && (idx == REG_ROW_WIDTH || idx == REG_FRAME_HEIGHT);
	end

endmodule
`default_nettype wire

/* rtl/rnbe_front.sv */
// ============================================================================
// Front end
// Accepts samples, tracks the raster position and builds result items.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module rnbe_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  rnbe_pkg::cfg_t                      cfg,
	input  wire logic                           in_valid,
	input  rnbe_pkg::sample_t                   in_sample,
	input  wire logic                           q_full,
	output logic                                in_ready,
	output logic                                push,
	output rnbe_pkg::item_t                     push_item
);
	import rnbe_pkg::*;

	sample_t               prev_q;
	sample_t               older_q;
	logic [CNT_BITS-1:0]   col_q;
	logic [HCNT_BITS-1:0]  row_q;
	logic [CNT_BITS-1:0]   c;
	logic [HCNT_BITS-1:0]  rc;
	logic [EW_BITS-1:0]    c_next;
	logic [EH_BITS-1:0]    r_next;
	logic                  last_row;
	logic                  w_one;
	logic                  c_end;
	logic                  accept;
	sample_t               left_a;
	sample_t               pick_a;
	sample_t               pick_b;

	function automatic sample_t pick(input sample_t left, input sample_t cur,
		input sample_t right, input logic [DTHR_BITS-1:0] dt,
		input logic signed [BTHR_BITS-1:0] bt);
		logic signed [CMP_BITS-1:0] diff;
		logic signed [CMP_BITS-1:0] dts;
		logic signed [CMP_BITS-1:0] bts;
		sample_t                    res;
		diff = CMP_BITS'(left) - CMP_BITS'(right);
		dts  = $signed(CMP_BITS'(dt));
		bts  = CMP_BITS'(bt);
		if (diff >= dts && CMP_BITS'(left) >= bts) begin
			res = right;
		end else if (diff <= -dts && CMP_BITS'(right) >= bts) begin
			res = left;
		end else begin
			res = cur;
		end
		return res;
	endfunction

	assign in_ready = !q_full && !cfg.geom_clear;
	assign accept   = in_valid && in_ready;

	always_comb begin
		c        = (EW_BITS'(col_q) >= cfg.width) ? '0 : col_q;
		rc       = (EH_BITS'(row_q) >= cfg.height) ? '0 : row_q;
		last_row = (EH_BITS'(rc) == cfg.height - EH_BITS'(1));
		w_one    = (cfg.width == EW_BITS'(1));
		c_end    = (EW_BITS'(c) == cfg.width - EW_BITS'(1));
		left_a   = (c == CNT_BITS'(1)) ? in_sample : older_q;
		pick_a   = pick(left_a, prev_q, in_sample, cfg.diff_thr, cfg.bright_thr);
		pick_b   = pick(prev_q, in_sample, prev_q, cfg.diff_thr, cfg.bright_thr);
		c_next   = EW_BITS'(c) + EW_BITS'(1);
		r_next   = EH_BITS'(rc) + EH_BITS'(1);

		push_item.two          = !w_one && c_end;
		push_item.r0.sample    = w_one ? in_sample : pick_a;
		push_item.r0.row_end   = w_one;
		push_item.r0.frame_end = w_one && last_row;
		push_item.r1.sample    = pick_b;
		push_item.r1.row_end   = 1'b1;
		push_item.r1.frame_end = last_row;
		push = accept && (w_one || c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			older_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg.geom_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			older_q <= prev_q;
			prev_q  <= in_sample;
			if (c_next >= cfg.width) begin
				col_q <= '0;
				row_q <= (r_next >= cfg.height) ? '0 : r_next[HCNT_BITS-1:0];
			end else begin
				col_q <= c_next[CNT_BITS-1:0];
				row_q <= rc;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rnbe_queue.sv */
// ============================================================================
// Item queue
// Short register FIFO between the front end and the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module rnbe_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  rnbe_pkg::item_t push_item,
	input  wire logic      pop,
	output logic           full,
	output logic           nonempty,
	output rnbe_pkg::item_t head
);
	import rnbe_pkg::*;

	item_t                mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_pop;

	assign full     = (count_q == (QPTR_BITS + 1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_BITS'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QPTR_BITS + 1)'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - (QPTR_BITS + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rnbe_back.sv */
// ============================================================================
// Back end
// Unpacks queued items into single result words on the output stream.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module rnbe_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_nonempty,
	input  rnbe_pkg::item_t                    q_head,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [rnbe_pkg::TDATA_BITS-1:0]    m_tdata,
	output logic                               m_tlast,
	output logic [1:0]                         m_tuser
);
	import rnbe_pkg::*;

	item_t   item_q;
	logic    valid_q;
	logic    idx_q;
	result_t cur;
	logic    last;
	logic    fire;
	logic    advance;

	always_comb begin
		cur      = idx_q ? item_q.r1 : item_q.r0;
		last     = !item_q.two || idx_q;
		fire     = valid_q && m_tready;
		advance  = (fire && last) || !valid_q;
		pop      = advance && q_nonempty;
		m_tvalid = valid_q;
		m_tdata  = TDATA_BITS'($unsigned(cur.sample));
		m_tlast  = cur.row_end;
		m_tuser  = {last, cur.frame_end};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (fire && !last) begin
			idx_q <= 1'b1;
		end else if (advance) begin
			valid_q <= q_nonempty;
			idx_q   <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* rtl/rnbe_checker.sv */
// ============================================================================
// Port checker
// Concurrent checks on the top level ports, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "row_neighbor_bright_edge_filter_top_defines.svh"
module rnbe_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pready,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [rnbe_pkg::TDATA_BITS-1:0] m_tdata,
	input  wire logic                            m_tlast,
	input  wire logic [1:0]                      m_tuser
);

	`RNBE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output word changed while stalled")
	`RNBE_ASSERT_IMPL(a_frame_in_row, m_tvalid && m_tuser[0], m_tlast, "frame end without row end")
	`RNBE_ASSERT_IMPL(a_row_end_last, m_tvalid && m_tlast, m_tuser[1], "row end word not last of its sample")
	`RNBE_ASSERT_IMPL(a_pready, 1'b1, pready, "configuration port not ready")

endmodule

bind row_neighbor_bright_edge_filter_top rnbe_checker u_rnbe_checker (.*);
`default_nettype wire

/* verif/row_filter_monitor.sv */
// ============================================================================
// Row neighbor bright edge filter stream monitor
// Watches the register port and both streams, predicts every result word
// from the accepted samples and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps
module row_filter_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rnbe_pkg::PADDR_BITS-1:0] paddr,
	input  logic [rnbe_pkg::PDATA_BITS-1:0] pwdata,
	input  logic                            pready,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rnbe_pkg::TDATA_BITS-1:0] s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rnbe_pkg::TDATA_BITS-1:0] m_tdata,
	input  logic                            m_tlast,
	input  logic [1:0]                      m_tuser,
	output int                              fail_count,
	output int                              pending_count
);
	import rnbe_pkg::*;

	typedef struct packed {
		sample_t sample;
		logic    row_end;
		logic    frame_end;
		logic    run_last;
	} filter_word_t;

	logic [CFG_GEOM_BITS-1:0]    row_width;
	logic [CFG_GEOM_BITS-1:0]    frame_height;
	logic [DTHR_BITS-1:0]        diff_thr;
	logic signed [BTHR_BITS-1:0] bright_thr;

	sample_t            prev_smp;
	sample_t            older_smp;
	logic [EW_BITS-1:0] col_pos;
	logic [EH_BITS-1:0] row_pos;

	filter_word_t due_words[$];

	function automatic sample_t choose_pixel(sample_t left, sample_t center, sample_t right);
		logic signed [SAMPLE_BITS+1:0] step;
		logic signed [SAMPLE_BITS+1:0] limit;
		step = left - right;
		limit = {3'b000, diff_thr};
		if (step >= limit && left >= bright_thr)
			return right;
		if (step <= -limit && right >= bright_thr)
			return left;
		return center;
	endfunction

	task automatic filter_sample(input sample_t x);
		logic [EW_BITS-1:0] w;
		logic [EH_BITS-1:0] h;
		logic [EW_BITS-1:0] c;
		logic               last_row;
		filter_word_t       made[2];
		int                 n;
		if (row_width == '0)
			w = EW_BITS'(1);
		else if (row_width > MAX_WIDTH)
			w = EW_BITS'(MAX_WIDTH);
		else
			w = row_width;
		if (frame_height == '0)
			h = EH_BITS'(1);
		else if (frame_height > HEIGHT_LIMIT)
			h = EH_BITS'(HEIGHT_LIMIT);
		else
			h = frame_height;
		c = col_pos;
		if (c >= w)
			c = '0;
		if (row_pos >= h)
			row_pos = '0;
		last_row = (row_pos == h - 1'b1);
		n = 0;
		if (w == 1) begin
			made[0] = '{x, 1'b1, last_row, 1'b0};
			n = 1;
		end else begin
			if (c >= 1) begin
				made[n] = '{choose_pixel((c == 1) ? x : older_smp, prev_smp, x), 1'b0, 1'b0, 1'b0};
				n++;
			end
			if (c == w - 1'b1) begin
				made[n] = '{choose_pixel(prev_smp, x, prev_smp), 1'b1, last_row, 1'b0};
				n++;
			end
		end
		if (n > 0)
			made[n-1].run_last = 1'b1;
		for (int k = 0; k < n; k++)
			due_words.push_back(made[k]);
		older_smp = prev_smp;
		prev_smp = x;
		c = c + 1'b1;
		if (c >= w) begin
			c = '0;
			row_pos = row_pos + 1'b1;
			if (row_pos >= h)
				row_pos = '0;
		end
		col_pos = c;
	endtask

	task automatic check_word();
		filter_word_t want;
		if (due_words.size() == 0) begin
			$error("result word with nothing expected: sample_out %0d",
				$signed(m_tdata[SAMPLE_BITS-1:0]));
			fail_count++;
		end else begin
			want = due_words.pop_front();
			if (m_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
				$error("sample_out expected %0d actual %0d", want.sample,
					$signed(m_tdata[SAMPLE_BITS-1:0]));
				fail_count++;
			end
			if (m_tlast !== want.row_end) begin
				$error("row_end expected %0b actual %0b", want.row_end, m_tlast);
				fail_count++;
			end
			if (m_tuser[0] !== want.frame_end) begin
				$error("frame_end expected %0b actual %0b", want.frame_end, m_tuser[0]);
				fail_count++;
			end
			if (m_tuser[1] !== want.run_last) begin
				$error("run_last expected %0b actual %0b", want.run_last, m_tuser[1]);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width = 13'd512;
			frame_height = 13'd512;
			diff_thr = 19'd1280;
			bright_thr = 20'sd40960;
			prev_smp = '0;
			older_smp = '0;
			col_pos = '0;
			row_pos = '0;
			due_words.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_word();
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[3:2]))
					REG_ROW_WIDTH: begin
						row_width = pwdata[CFG_GEOM_BITS-1:0];
						col_pos = '0;
						row_pos = '0;
					end
					REG_FRAME_HEIGHT: begin
						frame_height = pwdata[CFG_GEOM_BITS-1:0];
						col_pos = '0;
						row_pos = '0;
					end
					REG_DIFF_THR: diff_thr = pwdata[DTHR_BITS-1:0];
					REG_BRIGHT_THR: bright_thr = pwdata[BTHR_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				filter_sample(s_tdata[SAMPLE_BITS-1:0]);
			pending_count = due_words.size();
		end
	end

endmodule

/* verif/tb.sv */
// ============================================================================
// Row neighbor bright edge filter testbench
// Drives directed and shaped random sample streams through several
// geometries and threshold settings, with random idling on both streams,
// two long receiver stalls and drained pauses. The monitor predicts and checks.
// ============================================================================
`timescale 1ns / 1ps
module tb;
	import rnbe_pkg::*;

	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
	localparam int     HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TDATA_BITS-1:0] s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tlast;
	logic [1:0]            m_tuser;

	int fail_count;
	int pending_count;

	int     send_idle_pct = 18;
	int     recv_idle_pct = 82;
	int     hold_asked = 0;
	int     hold_seen = 0;
	int     hold_left = 0;
	longint cur_dt;
	longint cur_bt;
	longint last_level = 0;

	row_neighbor_bright_edge_filter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	row_filter_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic apb_write(input reg_index_t idx, input logic [PDATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [PDATA_BITS-1:0] w, input logic [PDATA_BITS-1:0] h);
		apb_write(REG_ROW_WIDTH, w);
		apb_write(REG_FRAME_HEIGHT, h);
	endtask

	task automatic set_thresholds(input longint dt, input longint bt);
		cur_dt = dt;
		cur_bt = bt;
		apb_write(REG_DIFF_THR, PDATA_BITS'(dt));
		apb_write(REG_BRIGHT_THR, PDATA_BITS'(bt));
	endtask

	task automatic push_sample(input sample_t v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_BITS - SAMPLE_BITS){1'b0}}, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Let every result word arrive, then give the pipeline time to go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Samples cluster around the thresholds so that both edge rules fire and miss.
	function automatic sample_t shaped_sample();
		longint v;
		case ($urandom_range(0, 9))
			0, 1: return sample_t'($urandom);
			2: v = cur_bt + longint'($urandom_range(0, 2)) - 1;
			3: v = cur_bt + longint'($urandom_range(0, 4000));
			4: v = cur_bt - cur_dt + longint'($urandom_range(0, 2)) - 1;
			5: v = cur_bt - cur_dt - longint'($urandom_range(0, 4000));
			6: v = $urandom_range(0, 1) ? SAMPLE_LO : SAMPLE_HI;
			default: v = last_level;
		endcase
		if (v > SAMPLE_HI)
			v = SAMPLE_HI;
		if (v < SAMPLE_LO)
			v = SAMPLE_LO;
		last_level = v;
		return sample_t'(v);
	endfunction

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [PDATA_BITS-1:0] geo_w;
		logic [PDATA_BITS-1:0] geo_h;
		longint                dt_pick;
		longint                bt_pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cur_dt = 1280;
		cur_bt = 40960;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Width one with sample extremes.
		set_geometry(1, 1);
		set_thresholds(1280, 40960);
		push_sample(sample_t'(SAMPLE_LO));
		push_sample(sample_t'(SAMPLE_HI));
		push_sample(0);
		settle();

		// Zero difference threshold and lowest bright threshold.
		set_geometry(4, 2);
		set_thresholds(0, SAMPLE_LO);
		push_sample(sample_t'(SAMPLE_HI));
		push_sample(sample_t'(SAMPLE_LO));
		push_sample(0);
		push_sample(-1);
		push_sample(sample_t'(SAMPLE_HI));
		push_sample(sample_t'(SAMPLE_LO));
		settle();

		// Highest thresholds, height zero.
		set_geometry(3, 0);
		set_thresholds(524287, SAMPLE_HI);
		push_sample(sample_t'(SAMPLE_HI));
		push_sample(0);
		push_sample(sample_t'(SAMPLE_LO));
		settle();

		// Width zero.
		set_geometry(0, 8191);
		push_sample(7);
		push_sample(-7);
		settle();

		// Oversized geometry with a bright step.
		set_geometry(8191, 8191);
		set_thresholds(1280, 40960);
		push_sample(50000);
		push_sample(20000);
		push_sample(0);
		push_sample(0);
		settle();

		// Geometry rewritten mid-row, then thresholds rewritten mid-row.
		set_geometry(5, 2);
		push_sample(50000);
		push_sample(10);
		push_sample(0);
		settle();
		set_geometry(5, 2);
		push_sample(1);
		push_sample(2);
		push_sample(3);
		settle();
		set_thresholds(0, 0);
		push_sample(4);
		push_sample(5);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph % 3 != 2) begin
				case ($urandom_range(0, 9))
					0: geo_w = 0;
					1: geo_w = 1;
					2: geo_w = 2;
					default: geo_w = $urandom_range(3, 12);
				endcase
				geo_h = $urandom_range(0, 4);
				set_geometry(geo_w, geo_h);
			end
			case ($urandom_range(0, 5))
				0: dt_pick = 0;
				1: dt_pick = 524287;
				2: dt_pick = longint'($urandom & 32'h7FFFF);
				default: dt_pick = longint'($urandom_range(1, 3000));
			endcase
			case ($urandom_range(0, 5))
				0: bt_pick = SAMPLE_LO;
				1: bt_pick = SAMPLE_HI;
				2: bt_pick = longint'(sample_t'($urandom));
				default: bt_pick = longint'($urandom_range(0, 60000)) - 20000;
			endcase
			set_thresholds(dt_pick, bt_pick);
			if (ph == 1 || ph == 9)
				hold_asked++;
			for (int i = 0; i < 32; i++) begin
				if (ph == 5 && i == 17)
					settle();
				push_sample(shaped_sample());
			end
			settle();
		end

		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
